FILE: rtl/core/ehpp_pkg.sv
// ----------------------------------------------------------------------------
// ehpp_pkg
// Shared types and constants of the EEG headset packet parser: frame and row
// phases, row codes, status codes and the control group between the framer
// and the row decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ehpp_pkg;

  // Framing constants
  localparam logic [7:0] SyncByte      = 8'hAA;
  localparam logic [7:0] MaxLenReset   = 8'd169;
  localparam logic [7:0] QualityAbsent = 8'd200;
  localparam logic [7:0] ShortLength   = 8'd4;

  // Row codes
  localparam logic [7:0] CodeQuality    = 8'h02;
  localparam logic [7:0] CodeAttention  = 8'h04;
  localparam logic [7:0] CodeMeditation = 8'h05;
  localparam logic [7:0] CodeSkipThree  = 8'h80;
  localparam logic [7:0] CodeBands      = 8'h83;

  // Band storage
  localparam int unsigned BandCount   = 8;
  localparam int unsigned BandIdxW    = $clog2(BandCount);
  localparam int unsigned BandW       = 24;
  localparam int unsigned BandBytes   = 3;
  localparam int unsigned ByteSelW    = 2;
  localparam logic [BandIdxW-1:0] LastBand     = BandIdxW'(BandCount - 1);
  localparam logic [ByteSelW-1:0] LastBandByte = ByteSelW'(BandBytes - 1);

  typedef logic [BandCount-1:0][BandW-1:0] band_array_t;

  // Result status codes
  localparam logic [1:0] StatusValid          = 2'd0;
  localparam logic [1:0] StatusNoQuality      = 2'd1;
  localparam logic [1:0] StatusShortNoQuality = 2'd2;

  // Packet framing phase
  typedef enum logic [2:0] {
    FrHunt1,
    FrHunt2,
    FrLength,
    FrPayload,
    FrCheck
  } frame_phase_e;

  // Row decoding phase
  typedef enum logic [2:0] {
    FdCode,
    FdQuality,
    FdAttention,
    FdMeditation,
    FdSkip,
    FdBandLead,
    FdBand
  } field_phase_e;

  // Framer to row decoder
  typedef struct packed {
    logic clear;   // new packet: restore staged values
    logic parse;   // payload beat to decode
  } ehpp_ctl_t;

endpackage : ehpp_pkg

`default_nettype wire

FILE: rtl/core/ehpp_row_decoder.sv
// ----------------------------------------------------------------------------
// ehpp_row_decoder
// Decodes payload rows byte by byte and holds the staged readings of the
// packet in progress: quality, attention, meditation and the band powers.
// ----------------------------------------------------------------------------
`default_nettype none

module ehpp_row_decoder (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ehpp_pkg::ehpp_ctl_t  ctl_i,
  input  wire logic [7:0]           data_i,
  output logic [7:0]                quality_o,
  output logic [7:0]                attention_o,
  output logic [7:0]                meditation_o,
  output ehpp_pkg::band_array_t     bands_o
);
  import ehpp_pkg::*;

  field_phase_e          field_q, field_d;
  logic [1:0]            skip_q, skip_d;
  logic [BandIdxW-1:0]   band_sel_q, band_sel_d;
  logic [ByteSelW-1:0]   byte_sel_q, byte_sel_d;
  logic [7:0]            quality_q, quality_d;
  logic [7:0]            attention_q, attention_d;
  logic [7:0]            meditation_q, meditation_d;
  band_array_t           bands_q, bands_d;
  logic [BandW-1:0]      band_byte;

  // Next row phase
  always_comb begin
    field_d = field_q;
    if (ctl_i.clear) begin
      field_d = FdCode;
    end else if (ctl_i.parse) begin
      unique case (field_q)
        FdQuality, FdAttention, FdMeditation: field_d = FdCode;
        FdSkip: begin
          if (skip_q == 2'd1) field_d = FdCode;
        end
        FdBandLead: field_d = FdBand;
        FdBand: begin
          if (byte_sel_q == LastBandByte && band_sel_q == LastBand) field_d = FdCode;
        end
        default: begin
          unique case (data_i)
            CodeQuality:    field_d = FdQuality;
            CodeAttention:  field_d = FdAttention;
            CodeMeditation: field_d = FdMeditation;
            CodeSkipThree:  field_d = FdSkip;
            CodeBands:      field_d = FdBandLead;
            default:        field_d = FdCode;
          endcase
        end
      endcase
    end
  end

  // Place the beat at its big-endian position within a band
  always_comb begin
    case (byte_sel_q)
      2'd0:    band_byte = {data_i, 16'h0000};
      2'd1:    band_byte = {8'h00, data_i, 8'h00};
      default: band_byte = {16'h0000, data_i};
    endcase
  end

  // Staged values and row counters
  always_comb begin
    skip_d       = skip_q;
    band_sel_d   = band_sel_q;
    byte_sel_d   = byte_sel_q;
    quality_d    = quality_q;
    attention_d  = attention_q;
    meditation_d = meditation_q;
    bands_d      = bands_q;
    if (ctl_i.clear) begin
      skip_d       = 2'd0;
      band_sel_d   = '0;
      byte_sel_d   = '0;
      quality_d    = QualityAbsent;
      attention_d  = 8'd0;
      meditation_d = 8'd0;
      bands_d      = '0;
    end else if (ctl_i.parse) begin
      unique case (field_q)
        FdQuality:    quality_d    = data_i;
        FdAttention:  attention_d  = data_i;
        FdMeditation: meditation_d = data_i;
        FdSkip:       skip_d       = skip_q - 2'd1;
        FdBandLead: begin
          band_sel_d = '0;
          byte_sel_d = '0;
        end
        FdBand: begin
          bands_d[band_sel_q] = bands_q[band_sel_q] | band_byte;
          if (byte_sel_q == LastBandByte) begin
            byte_sel_d = '0;
            band_sel_d = (band_sel_q == LastBand) ? '0 : band_sel_q + 1'b1;
          end else begin
            byte_sel_d = byte_sel_q + 1'b1;
          end
        end
        default: begin
          if (data_i == CodeSkipThree) skip_d = 2'd3;
        end
      endcase
    end
  end

  // Hold state between beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q      <= FdCode;
      skip_q       <= 2'd0;
      band_sel_q   <= '0;
      byte_sel_q   <= '0;
      quality_q    <= QualityAbsent;
      attention_q  <= 8'd0;
      meditation_q <= 8'd0;
      bands_q      <= '0;
    end else begin
      field_q      <= field_d;
      skip_q       <= skip_d;
      band_sel_q   <= band_sel_d;
      byte_sel_q   <= byte_sel_d;
      quality_q    <= quality_d;
      attention_q  <= attention_d;
      meditation_q <= meditation_d;
      bands_q      <= bands_d;
    end
  end

  assign quality_o    = quality_q;
  assign attention_o  = attention_q;
  assign meditation_o = meditation_q;
  assign bands_o      = bands_q;

endmodule : ehpp_row_decoder

`default_nettype wire

FILE: rtl/core/eeg_headset_packet_parser.sv
// ----------------------------------------------------------------------------
// eeg_headset_packet_parser
// Packet framer for a serial EEG headset stream with row decoding and a
// registered result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / rx_byte_i) carries one received
//   byte per beat. The block finds two 0xAA sync bytes and a length byte,
//   decodes the payload rows as they arrive and checks the checksum byte.
//   Output channel (out_valid_o / out_ready_i) carries one result per packet
//   whose checksum matches; bad packets give no beat.
//   Throughput: one byte per cycle while in_ready_o is high. Latency: the
//   result is presented in the cycle after the checksum beat is accepted,
//   from the output register.
//   Stall: while a result waits, bytes of the next packet are still taken;
//   in_ready_o drops only when a checksum byte is due and the output
//   register is still full.
//   cfg_we_i / cfg_wdata_i write the largest payload length (169 after
//   reset); write it only while the block is idle.
//   Reset: asynchronous, active low; the block returns to hunting for sync,
//   the output register empties and staged readings take their reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module eeg_headset_packet_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       packet_status_o,
  output logic [7:0]       signal_quality_o,
  output logic [7:0]       attention_level_o,
  output logic [7:0]       meditation_level_o,
  output logic [23:0]      band_delta_o,
  output logic [23:0]      band_theta_o,
  output logic [23:0]      band_low_alpha_o,
  output logic [23:0]      band_high_alpha_o,
  output logic [23:0]      band_low_beta_o,
  output logic [23:0]      band_high_beta_o,
  output logic [23:0]      band_low_gamma_o,
  output logic [23:0]      band_mid_gamma_o
);
  import ehpp_pkg::*;

  frame_phase_e  frame_q, frame_d;
  logic [7:0]    max_len_q;
  logic [7:0]    left_q, left_d;
  logic [7:0]    sum_q, sum_d;
  logic          len_four_q, len_four_d;
  logic          beat;
  logic          load;
  ehpp_ctl_t     ctl;
  logic [7:0]    quality, attention, meditation;
  band_array_t   bands;
  logic          out_valid_q;
  logic [1:0]    status_q, status_d;
  logic [7:0]    quality_q, attention_q, meditation_q;
  band_array_t   bands_q;

  // Accept a byte unless a checksum is due and a held result is not taken
  assign in_ready_o = !(frame_q == FrCheck && out_valid_q && !out_ready_i);
  assign beat       = in_valid_i && in_ready_o;

  // Next framing phase
  always_comb begin
    frame_d = frame_q;
    if (beat) begin
      unique case (frame_q)
        FrHunt2:  frame_d = (rx_byte_i == SyncByte) ? FrLength : FrHunt1;
        FrLength: begin
          if (rx_byte_i > max_len_q)    frame_d = FrHunt1;
          else if (rx_byte_i == 8'd0)   frame_d = FrCheck;
          else                          frame_d = FrPayload;
        end
        FrPayload: begin
          if (left_q == 8'd1) frame_d = FrCheck;
        end
        FrCheck:  frame_d = FrHunt1;
        default:  frame_d = (rx_byte_i == SyncByte) ? FrHunt2 : FrHunt1;
      endcase
    end
  end

  // Framing outputs: decoder control, counters, checksum and result load
  always_comb begin
    ctl        = '0;
    load       = 1'b0;
    left_d     = left_q;
    sum_d      = sum_q;
    len_four_d = len_four_q;
    if (beat) begin
      unique case (frame_q)
        FrLength: begin
          if (rx_byte_i <= max_len_q) begin
            ctl.clear  = 1'b1;
            left_d     = rx_byte_i;
            sum_d      = 8'd0;
            len_four_d = (rx_byte_i == ShortLength);
          end
        end
        FrPayload: begin
          ctl.parse = 1'b1;
          sum_d     = sum_q + rx_byte_i;
          left_d    = left_q - 8'd1;
        end
        FrCheck:  load = (rx_byte_i == ~sum_q);
        default:  ;
      endcase
    end
  end

  ehpp_row_decoder u_rows (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .data_i       (rx_byte_i),
    .quality_o    (quality),
    .attention_o  (attention),
    .meditation_o (meditation),
    .bands_o      (bands)
  );

  // Status of the finished packet
  always_comb begin
    if (quality != QualityAbsent) status_d = StatusValid;
    else if (len_four_q)          status_d = StatusShortNoQuality;
    else                          status_d = StatusNoQuality;
  end

  // Framer state and length limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q    <= FrHunt1;
      max_len_q  <= MaxLenReset;
      left_q     <= 8'd0;
      sum_q      <= 8'd0;
      len_four_q <= 1'b0;
    end else begin
      frame_q    <= frame_d;
      left_q     <= left_d;
      sum_q      <= sum_d;
      len_four_q <= len_four_d;
      if (cfg_we_i) max_len_q <= cfg_wdata_i;
    end
  end

  // Output valid: set on load, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q     <= status_d;
      quality_q    <= quality;
      attention_q  <= attention;
      meditation_q <= meditation;
      bands_q      <= bands;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign packet_status_o    = status_q;
  assign signal_quality_o   = quality_q;
  assign attention_level_o  = attention_q;
  assign meditation_level_o = meditation_q;
  assign band_delta_o       = bands_q[0];
  assign band_theta_o       = bands_q[1];
  assign band_low_alpha_o   = bands_q[2];
  assign band_high_alpha_o  = bands_q[3];
  assign band_low_beta_o    = bands_q[4];
  assign band_high_beta_o   = bands_q[5];
  assign band_low_gamma_o   = bands_q[6];
  assign band_mid_gamma_o   = bands_q[7];

endmodule : eeg_headset_packet_parser

`default_nettype wire

FILE: rtl/core/ehpp_checker.sv
// ----------------------------------------------------------------------------
// ehpp_checker
// Port-level checks on the packet parser's result channel, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ehpp_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_o,
  input  wire logic        out_valid_o,
  input  wire logic        out_ready_i,
  input  wire logic [1:0]  packet_status_o,
  input  wire logic [7:0]  signal_quality_o
);
  import ehpp_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(packet_status_o) && $stable(signal_quality_o))
    else $error("result beat changed while stalled");

  // A result only follows an accepted byte
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result appeared without an accepted byte");

  // Status is one of the defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> packet_status_o == StatusValid || packet_status_o == StatusNoQuality ||
                    packet_status_o == StatusShortNoQuality)
    else $error("undefined packet status");

  // Status agrees with the reported quality
  a_status_quality: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((packet_status_o == StatusValid) == (signal_quality_o != QualityAbsent)))
    else $error("packet status disagrees with signal quality");

endmodule : ehpp_checker

bind eeg_headset_packet_parser ehpp_checker u_ehpp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .packet_status_o  (packet_status_o),
  .signal_quality_o (signal_quality_o)
);

`default_nettype wire
